// ===== hw/rtl/axis_argmax_argmin_top_assert.svh =====
// Assertion macros used by the arg-max / arg-min top level.
`ifndef AXIS_ARGMAX_ARGMIN_TOP_ASSERT_SVH
`define AXIS_ARGMAX_ARGMIN_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define AAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AAM_ASSERT(lbl, prop, msg)
`define AAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/aam_pkg.sv =====
// Shared constants, register codes and types of the arg-max / arg-min block.
`default_nettype none

package aam_pkg;

  localparam int AAM_MAX_INNER   = 256;
  localparam int AAM_VALUE_WIDTH = 32;
  localparam int AAM_IDX_W       = 16;
  localparam int AAM_CFG_IDX_W   = 2;
  localparam int AAM_CFG_DATA_W  = 16;

  localparam logic [AAM_CFG_IDX_W-1:0] CFG_SELECT_MIN  = 2'd0;
  localparam logic [AAM_CFG_IDX_W-1:0] CFG_AXIS_LENGTH = 2'd1;
  localparam logic [AAM_CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd2;
  localparam logic [AAM_CFG_IDX_W-1:0] CFG_OUTER_COUNT = 2'd3;

  typedef struct packed {
    logic [AAM_IDX_W-1:0] axis_idx;
    logic                 first_row;
    logic                 last_axis;
    logic                 tensor_done;
  } aam_pos_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aam_ifs.sv =====
// Valid/ready channel interfaces for the input, result and configuration words.
`default_nettype none

interface aam_in_if import aam_pkg::*; #(
  parameter int W = AAM_VALUE_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface aam_out_if import aam_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AAM_IDX_W-1:0] best_index;
  logic                 tensor_done;

  modport source (output valid, best_index, tensor_done, input ready);
  modport sink (input valid, best_index, tensor_done, output ready);
endinterface

interface aam_cfg_if import aam_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [AAM_CFG_IDX_W-1:0]  index;
  logic [AAM_CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/axis_argmax_argmin_top.sv =====
// Top level of the streaming arg-max / arg-min reduction along one tensor axis.
//
// Input words carry one signed tensor element each, in memory order (outer,
// axis, inner). For every inner position the block tracks the best value and
// its axis index; on the last axis row each input word produces one result
// word with the final index, and tensor_done marks the last result of the
// tensor. Other input words produce no result.
// The configuration channel is always ready and takes a register index and
// data: select_min, axis_length, inner_size, outer_count. Write it only while
// no word is in flight.
// One input word is accepted every cycle while in_ch.ready is high. A result first
// passes the compare stage, which the accepting edge loads with the word and the
// store read, and then the output register, loaded when the compare stage fires.
// The store is a single RAM with one read and one write port; a back-to-back
// update of the same position is forwarded around the RAM.
// When the receiver stalls, the output register holds its word and the block
// keeps accepting input until a second result would have to wait; then
// in_ch.ready drops until the output is taken.
// Reset sets the registers to select_min 0 and the other three to 1 and
// clears the counters. The store is not cleared; no clearing pass runs.
`default_nettype none
`include "axis_argmax_argmin_top_assert.svh"

module axis_argmax_argmin_top import aam_pkg::*; #(
  parameter int MAX_INNER   = AAM_MAX_INNER,
  parameter int VALUE_WIDTH = AAM_VALUE_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aam_in_if.sink     in_ch,
  aam_out_if.source  out_ch,
  aam_cfg_if.sink    cfg_ch
);

  localparam int SAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int RW  = VALUE_WIDTH + AAM_IDX_W;

  logic                   sel_min_r;
  logic [AAM_IDX_W-1:0]   axis_len_r;
  logic [8:0]             inner_size_r;
  logic [AAM_IDX_W-1:0]   outer_cnt_r;

  logic                   in_acc, s1_fire;
  logic [SAW-1:0]         slot;
  aam_pos_t               pos;

  logic                   s1_valid_r;
  logic [SAW-1:0]         s1_slot_r;
  aam_pos_t               s1_pos_r;
  logic signed [VALUE_WIDTH-1:0] s1_key_r;

  logic                   byp_vld_r;
  logic [SAW-1:0]         byp_slot_r;
  logic signed [VALUE_WIDTH-1:0] byp_val_r;
  logic [AAM_IDX_W-1:0]   byp_idx_r;

  logic [RW-1:0]          ram_rdata;
  logic                   byp_hit, better;
  logic signed [VALUE_WIDTH-1:0] cur_val, wr_val;
  logic [AAM_IDX_W-1:0]   cur_idx, wr_idx;

  logic                   out_valid_r, out_valid_nxt;
  logic [AAM_IDX_W-1:0]   out_idx_r;
  logic                   out_done_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_min_r    <= 1'b0;
      axis_len_r   <= AAM_IDX_W'(1);
      inner_size_r <= 9'd1;
      outer_cnt_r  <= AAM_IDX_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SELECT_MIN:  sel_min_r    <= cfg_ch.data[0];
        CFG_AXIS_LENGTH: axis_len_r   <= cfg_ch.data;
        CFG_INNER_SIZE:  inner_size_r <= cfg_ch.data[8:0];
        CFG_OUTER_COUNT: outer_cnt_r  <= cfg_ch.data;
      endcase
    end
  end

  assign s1_fire     = s1_valid_r && !(s1_pos_r.last_axis && out_valid_r && !out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  aam_seq #(
    .MAX_INNER (MAX_INNER)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_acc),
    .axis_length (axis_len_r),
    .inner_size  (inner_size_r),
    .outer_count (outer_cnt_r),
    .slot        (slot),
    .pos         (pos)
  );

  aam_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_INNER)
  ) u_store (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_slot_r),
    .wdata ({wr_val, wr_idx}),
    .re    (in_acc),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        byp_vld_r  <= s1_fire;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot_r  <= slot;
      s1_pos_r   <= pos;
      s1_key_r   <= in_ch.value;
      byp_slot_r <= s1_slot_r;
      byp_val_r  <= wr_val;
      byp_idx_r  <= wr_idx;
    end
  end

  always_comb begin
    byp_hit = byp_vld_r && (byp_slot_r == s1_slot_r);
    cur_val = byp_hit ? byp_val_r : ram_rdata[RW-1:AAM_IDX_W];
    cur_idx = byp_hit ? byp_idx_r : ram_rdata[AAM_IDX_W-1:0];
    better  = sel_min_r ? (s1_key_r < cur_val) : (s1_key_r > cur_val);
    if (s1_pos_r.first_row) begin
      wr_val = s1_key_r;
      wr_idx = '0;
    end else if (better) begin
      wr_val = s1_key_r;
      wr_idx = s1_pos_r.axis_idx;
    end else begin
      wr_val = cur_val;
      wr_idx = cur_idx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_fire && s1_pos_r.last_axis) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_pos_r.last_axis) begin
      out_idx_r  <= wr_idx;
      out_done_r <= s1_pos_r.tensor_done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_index  = out_idx_r;
  assign out_ch.tensor_done = out_done_r;

  `AAM_ASSERT(a_stall_cause, (s1_valid_r && !s1_fire) |-> (out_valid_r && !out_ch.ready), "stage held without a blocked output")
  `AAM_ASSERT(a_ready_low, !in_ch.ready |-> s1_valid_r, "input refused with an empty stage")
  `AAM_ASSERT_NEXT(a_accept_fills, in_acc, s1_valid_r, "accepted word did not reach the compare stage")
  `AAM_ASSERT_NEXT(a_result_out, (s1_fire && s1_pos_r.last_axis), out_valid_r, "result word lost")
  `AAM_ASSERT(a_done_last, (s1_valid_r && s1_pos_r.tensor_done) |-> s1_pos_r.last_axis, "tensor end off the last axis row")

endmodule

`default_nettype wire

// ===== hw/rtl/aam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module aam_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aam_seq.sv =====
// Inner, axis and outer position counters that walk the tensor in memory order.
`default_nettype none

module aam_seq import aam_pkg::*; #(
  parameter int MAX_INNER = AAM_MAX_INNER,
  localparam int SAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
  localparam int CW = (SAW + 2 > 10) ? SAW + 2 : 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic [AAM_IDX_W-1:0] axis_length,
  input  wire logic [8:0]           inner_size,
  input  wire logic [AAM_IDX_W-1:0] outer_count,
  output logic      [SAW-1:0]       slot,
  output aam_pos_t                  pos
);

  logic [SAW-1:0]       inner_r, inner_nxt;
  logic [AAM_IDX_W-1:0] axis_r, axis_nxt;
  logic [AAM_IDX_W-1:0] outer_r, outer_nxt;
  logic [CW-1:0]        size_ext, eff_inner;
  logic [AAM_IDX_W:0]   n_axis, n_outer;
  logic                 last_inner, last_axis, last_outer;

  always_comb begin
    size_ext = CW'(inner_size);
    if (size_ext == '0) begin
      eff_inner = CW'(1);
    end else if (size_ext > CW'(MAX_INNER)) begin
      eff_inner = CW'(MAX_INNER);
    end else begin
      eff_inner = size_ext;
    end
    n_axis  = (axis_length == '0) ? (AAM_IDX_W+1)'(1) : {1'b0, axis_length};
    n_outer = (outer_count == '0) ? (AAM_IDX_W+1)'(1) : {1'b0, outer_count};

    last_inner = (CW'(inner_r) + CW'(1)) >= eff_inner;
    last_axis  = ({1'b0, axis_r} + (AAM_IDX_W+1)'(1)) >= n_axis;
    last_outer = ({1'b0, outer_r} + (AAM_IDX_W+1)'(1)) >= n_outer;

    inner_nxt = inner_r;
    axis_nxt  = axis_r;
    outer_nxt = outer_r;
    if (last_inner) begin
      inner_nxt = '0;
      if (last_axis) begin
        axis_nxt  = '0;
        outer_nxt = last_outer ? '0 : outer_r + AAM_IDX_W'(1);
      end else begin
        axis_nxt = axis_r + AAM_IDX_W'(1);
      end
    end else begin
      inner_nxt = inner_r + SAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      axis_r  <= '0;
      outer_r <= '0;
    end else if (adv) begin
      inner_r <= inner_nxt;
      axis_r  <= axis_nxt;
      outer_r <= outer_nxt;
    end
  end

  assign slot            = inner_r;
  assign pos.axis_idx    = axis_r;
  assign pos.first_row   = (axis_r == '0);
  assign pos.last_axis   = last_axis;
  assign pos.tensor_done = last_axis && last_inner && last_outer;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the arg-max / arg-min block: directed and random tensors.
module testbench import aam_pkg::*; ();

  localparam logic signed [AAM_VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(AAM_VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [AAM_VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(AAM_VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [AAM_IDX_W-1:0] best_index;
    logic                 tensor_done;
  } extreme_t;

  class argext_scoreboard;
    logic                              min_mode;
    logic [15:0]                       axis_len;
    logic [8:0]                        inner_len;
    logic [15:0]                       outer_len;
    logic signed [AAM_VALUE_WIDTH-1:0] best_val [AAM_MAX_INNER];
    logic [AAM_IDX_W-1:0]              best_idx [AAM_MAX_INNER];
    int unsigned                       inner_pos;
    int unsigned                       axis_pos;
    int unsigned                       outer_pos;
    extreme_t                          due_indices [$];
    int                                mismatches;

    function new();
      min_mode   = 1'b0;
      axis_len   = 16'd1;
      inner_len  = 9'd1;
      outer_len  = 16'd1;
      inner_pos  = 0;
      axis_pos   = 0;
      outer_pos  = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [AAM_CFG_IDX_W-1:0] id, logic [AAM_CFG_DATA_W-1:0] data);
      case (id)
        CFG_SELECT_MIN:  min_mode = data[0];
        CFG_AXIS_LENGTH: axis_len = data;
        CFG_INNER_SIZE:  inner_len = data[8:0];
        CFG_OUTER_COUNT: outer_len = data;
        default: ;
      endcase
    endfunction

    function bit at_origin();
      return inner_pos == 0 && axis_pos == 0 && outer_pos == 0;
    endfunction

    function void take_element(logic signed [AAM_VALUE_WIDTH-1:0] v);
      int unsigned n_inner;
      int unsigned n_axis;
      int unsigned n_outer;
      bit          last_inner;
      bit          last_axis;
      bit          last_outer;
      extreme_t    r;
      n_inner = (inner_len == 0) ? 1 : (inner_len > AAM_MAX_INNER) ? AAM_MAX_INNER : inner_len;
      n_axis  = (axis_len == 0) ? 1 : axis_len;
      n_outer = (outer_len == 0) ? 1 : outer_len;
      if (axis_pos == 0) begin
        best_val[inner_pos] = v;
        best_idx[inner_pos] = '0;
      end else if (min_mode ? (v < best_val[inner_pos]) : (v > best_val[inner_pos])) begin
        best_val[inner_pos] = v;
        best_idx[inner_pos] = axis_pos[AAM_IDX_W-1:0];
      end
      last_inner = (inner_pos + 1) >= n_inner;
      last_axis  = (axis_pos + 1) >= n_axis;
      last_outer = (outer_pos + 1) >= n_outer;
      if (last_axis) begin
        r.best_index  = best_idx[inner_pos];
        r.tensor_done = last_inner && last_outer;
        due_indices.push_back(r);
      end
      if (last_inner) begin
        inner_pos = 0;
        if (last_axis) begin
          axis_pos  = 0;
          outer_pos = last_outer ? 0 : ((outer_pos + 1) & 16'hFFFF);
        end else begin
          axis_pos = (axis_pos + 1) & 16'hFFFF;
        end
      end else begin
        inner_pos = inner_pos + 1;
      end
    endfunction

    function void check_index(logic [AAM_IDX_W-1:0] idx, logic done);
      extreme_t e;
      if (due_indices.size() == 0) begin
        $error("Unexpected result word: best_index %0d, tensor_done %0b.", idx, done);
        mismatches++;
        return;
      end
      e = due_indices.pop_front();
      if (idx !== e.best_index) begin
        $error("best_index: expected %0d, actual %0d", e.best_index, idx);
        mismatches++;
      end
      if (done !== e.tensor_done) begin
        $error("tensor_done: expected %0b, actual %0b", e.tensor_done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;

  always #6 clk = ~clk;

  aam_in_if  in_ch ();
  aam_out_if out_ch ();
  aam_cfg_if cfg_ch ();

  axis_argmax_argmin_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  argext_scoreboard sb = new();

  function automatic logic signed [AAM_VALUE_WIDTH-1:0] next_element();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return AAM_VALUE_WIDTH'($urandom_range(0, 6) - 3);
      default: return AAM_VALUE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic push_value(input logic signed [AAM_VALUE_WIDTH-1:0] v);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_element(v);
  endtask

  // Stops input and lets the pipeline empty before the next register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.due_indices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic sel, input logic [15:0] axis,
                            input logic [8:0] inner, input logic [15:0] outer);
    logic [AAM_CFG_IDX_W-1:0]  reg_id [4];
    logic [AAM_CFG_DATA_W-1:0] word [4];
    reg_id = '{CFG_SELECT_MIN, CFG_AXIS_LENGTH, CFG_INNER_SIZE, CFG_OUTER_COUNT};
    word[0] = AAM_CFG_DATA_W'($urandom);
    word[0][0] = sel;
    word[1] = axis;
    word[2] = AAM_CFG_DATA_W'($urandom);
    word[2][8:0] = inner;
    word[3] = outer;
    for (int k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_id[k];
      cfg_ch.data  <= word[k];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_reg(reg_id[k], word[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_index(out_ch.best_index, out_ch.tensor_done);
    end
  end

  initial begin : sink_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 9);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned big_left;
    int unsigned n_inner;
    int unsigned n_axis;
    int unsigned n_outer;
    int unsigned words;
    bit          paused;
    logic        sel;
    logic [15:0] axis;
    logic [8:0]  inner;
    logic [15:0] outer;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SELECT_MIN;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // After reset every word is a whole tensor of its own.
    push_value(VAL_MIN);
    push_value(VAL_MAX);
    settle();
    write_regs(1'b0, 16'd4, 9'd1, 16'd1);
    push_value(VAL_MIN);
    push_value(VAL_MAX);
    push_value(VAL_MAX);
    push_value(0);
    settle();
    write_regs(1'b1, 16'd4, 9'd1, 16'd1);
    push_value(VAL_MAX);
    push_value(VAL_MIN);
    push_value(VAL_MIN);
    push_value(-1);
    settle();
    write_regs(1'b0, 16'd3, 9'd1, 16'd1);
    push_value(7);
    push_value(7);
    push_value(7);
    settle();
    write_regs(1'b1, 16'd0, 9'd0, 16'd0);
    push_value(5);
    push_value(-5);

    // Shrink the bounds while a tensor is half done.
    settle();
    write_regs(1'b0, 16'hFFFF, 9'd3, 16'hFFFF);
    repeat (6) push_value(next_element());
    settle();
    write_regs(1'b1, 16'd2, 9'd2, 16'd1);
    do push_value(next_element()); while (!sb.at_origin());
    settle();
    write_regs(1'b0, 16'd1, 9'd1, 16'hFFFF);
    repeat (3) push_value(next_element());
    settle();
    write_regs(1'b0, 16'd1, 9'd1, 16'd2);
    do push_value(next_element()); while (!sb.at_origin());

    rand_items = 0;
    big_left   = 2;
    paused     = 1'b0;
    while (rand_items < 1250) begin
      idle_on = (rand_items < 1000);
      sel = 1'($urandom_range(0, 1));
      if (big_left > 0 && $urandom_range(0, 5) == 0) begin
        big_left--;
        inner = 9'($urandom_range(200, 511));
        axis  = 16'($urandom_range(1, 2));
        outer = 16'd1;
      end else begin
        inner = 9'($urandom_range(0, 8));
        axis  = 16'($urandom_range(0, 9));
        outer = 16'($urandom_range(0, 3));
      end
      n_inner = (inner == 0) ? 1 : (inner > AAM_MAX_INNER) ? AAM_MAX_INNER : inner;
      n_axis  = (axis == 0) ? 1 : axis;
      n_outer = (outer == 0) ? 1 : outer;
      words   = n_inner * n_axis * n_outer;
      if (n_inner < 200) words = words * $urandom_range(1, 3);
      settle();
      write_regs(sel, axis, inner, outer);
      for (int w = 0; w < words; w++) begin
        if (!paused && words > 8 && w == words / 2) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (sb.due_indices.size() != 0);
        end
        push_value(next_element());
      end
      rand_items += words;
    end

    idle_on = 1'b0;
    settle();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== axis_argmax_argmin_top.f =====
+incdir+hw/rtl
hw/rtl/aam_pkg.sv
hw/rtl/aam_ifs.sv
hw/rtl/aam_ram.sv
hw/rtl/aam_seq.sv
hw/rtl/axis_argmax_argmin_top.sv
tb/sv/testbench.sv
